/* rtl/ret_pkg.sv */
// shared types, constants and codes for the ranked entry table
// no dependencies
`timescale 1ns / 1ps

package ret_pkg;

    localparam int CAPACITY = 256;
    localparam int ADDR_W   = $clog2(CAPACITY);

    localparam logic [1:0] CMD_ADD  = 2'd0;
    localparam logic [1:0] CMD_HARD = 2'd1;
    localparam logic [1:0] CMD_EASY = 2'd2;
    localparam logic [1:0] CMD_REM  = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_EMPTY    = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_NOTFOUND = 2'd3;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [15:0] problem_id;
        logic [7:0]  level;
    } t_in_item;

    typedef struct packed {
        logic [15:0] result_id;
        logic [1:0]  status;
    } t_out_item;

    typedef struct packed {
        logic [7:0]  level;
        logic [15:0] id;
    } t_entry;

    typedef struct packed {
        logic              wr_en;
        logic              set_vld;
        logic              clr_vld;
        logic [ADDR_W-1:0] addr;
        t_entry            data;
    } t_store_req;

    typedef struct packed {
        logic              seen;
        logic [15:0]       best_id;
        logic              hit;
        logic [ADDR_W-1:0] hit_idx;
        logic              free_ok;
        logic [ADDR_W-1:0] free_idx;
    } t_scan_res;

endpackage

/* rtl/ret_store.sv */
// entry memory with per-slot valid bits, one write and one registered read
// depends on ret_pkg
`timescale 1ns / 1ps

module ret_store import ret_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_store_req        i_req,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output t_entry            o_rd_data,
    output logic              o_rd_vld
);

    t_entry              r_mem [CAPACITY];
    logic [CAPACITY-1:0] r_vld;
    t_entry              r_rd_data;
    logic                r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.addr] <= i_req.data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_req.set_vld) begin
                r_vld[i_req.addr] <= 1'b1;
            end else if (i_req.clr_vld) begin
                r_vld[i_req.addr] <= 1'b0;
            end
            r_rd_vld <= r_vld[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
    assign o_rd_vld  = r_rd_vld;

endmodule

/* rtl/ret_scan.sv */
// shared compare unit that walks the table one slot per cycle
// tracks best rank key, identifier match and lowest free slot; depends on ret_pkg
`timescale 1ns / 1ps

module ret_scan import ret_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [1:0]        i_cmd,
    input  logic [15:0]       i_key_id,
    input  logic              i_act,
    input  logic [ADDR_W-1:0] i_idx,
    input  logic              i_ent_vld,
    input  t_entry            i_ent,
    output t_scan_res         o_res
);

    logic              r_seen;
    logic [23:0]       r_best;
    logic              r_hit;
    logic [ADDR_W-1:0] r_hit_idx;
    logic              r_free_ok;
    logic [ADDR_W-1:0] r_free_idx;

    logic [23:0] key;
    logic [23:0] cmp_a;
    logic [23:0] cmp_b;
    logic        better;
    logic        id_eq;
    logic        is_query;

    assign key      = {i_ent.level, i_ent.id};
    assign cmp_a    = (i_cmd == CMD_HARD) ? key : r_best;
    assign cmp_b    = (i_cmd == CMD_HARD) ? r_best : key;
    assign better   = cmp_a > cmp_b;
    assign id_eq    = i_ent.id == i_key_id;
    assign is_query = (i_cmd == CMD_HARD) || (i_cmd == CMD_EASY);

    always_ff @(posedge i_clk) begin
        if (i_act && i_ent_vld && is_query && (!r_seen || better)) begin
            r_best <= key;
        end
        if (i_act && i_ent_vld && !is_query && id_eq && !r_hit) begin
            r_hit_idx <= i_idx;
        end
        if (i_act && !i_ent_vld && !r_free_ok) begin
            r_free_idx <= i_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_start) begin
            r_seen    <= 1'b0;
            r_hit     <= 1'b0;
            r_free_ok <= 1'b0;
        end else if (i_act) begin
            if (i_ent_vld && is_query) begin
                r_seen <= 1'b1;
            end
            if (i_ent_vld && !is_query && id_eq) begin
                r_hit <= 1'b1;
            end
            if (!i_ent_vld) begin
                r_free_ok <= 1'b1;
            end
        end
    end

    assign o_res.seen     = r_seen;
    assign o_res.best_id  = r_best[15:0];
    assign o_res.hit      = r_hit;
    assign o_res.hit_idx  = r_hit_idx;
    assign o_res.free_ok  = r_free_ok;
    assign o_res.free_idx = r_free_idx;

endmodule

/* rtl/ranked_entry_table_min_max_query.sv */
// ranked entry table top level: sequencer, output register, store and scan unit
// depends on ret_pkg, ret_store, ret_scan
// every command scans all CAPACITY slots with one comparator, one slot per cycle
// one command at a time: no new item is taken until the previous result is registered
// reset: synchronous active low, clears all valid bits at once, table empty after reset
`timescale 1ns / 1ps

module ranked_entry_table_min_max_query import ret_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_LAST = 2'd2;
    localparam logic [1:0] S_FIN  = 2'd3;

    localparam logic [ADDR_W-1:0] LAST_IDX = ADDR_W'(CAPACITY - 1);

    logic [1:0]        r_state;
    logic [1:0]        n_state;
    logic [ADDR_W-1:0] r_cnt;
    logic              r_p_act;
    logic [ADDR_W-1:0] r_p_idx;
    t_in_item          r_item;
    logic              r_out_vld;
    t_out_item         r_out;

    logic       in_xfer;
    logic       fin_go;
    t_store_req req;
    t_entry     rd_data;
    logic       rd_vld;
    t_scan_res  res;
    t_out_item  n_out;

    assign in_xfer = i_in_valid && (r_state == S_IDLE);
    assign fin_go  = (r_state == S_FIN) && (!r_out_vld || !i_out_stall);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (in_xfer) n_state = S_SCAN;
            S_SCAN: if (r_cnt == LAST_IDX) n_state = S_LAST;
            S_LAST: n_state = S_FIN;
            S_FIN:  if (fin_go) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cnt     <= '0;
            r_p_act   <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            r_p_act <= (r_state == S_SCAN);
            if (r_state == S_SCAN) begin
                r_cnt <= r_cnt + 1'b1;
            end else begin
                r_cnt <= '0;
            end
            if (fin_go) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_p_idx <= r_cnt;
        if (in_xfer) begin
            r_item <= i_in_data;
        end
        if (fin_go) begin
            r_out <= n_out;
        end
    end

    always_comb begin
        req           = '0;
        req.data.id    = r_item.problem_id;
        req.data.level = r_item.level;
        n_out         = '0;
        unique case (r_item.cmd)
            CMD_ADD: begin
                if (res.hit) begin
                    req.addr = res.hit_idx;
                end else begin
                    req.addr = res.free_idx;
                end
                if (res.hit || res.free_ok) begin
                    req.wr_en   = fin_go;
                    req.set_vld = fin_go;
                    n_out.status = ST_OK;
                end else begin
                    n_out.status = ST_FULL;
                end
            end
            CMD_HARD, CMD_EASY: begin
                if (res.seen) begin
                    n_out.result_id = res.best_id;
                    n_out.status    = ST_OK;
                end else begin
                    n_out.status = ST_EMPTY;
                end
            end
            CMD_REM: begin
                req.addr = res.hit_idx;
                if (res.hit) begin
                    req.clr_vld  = fin_go;
                    n_out.status = ST_OK;
                end else begin
                    n_out.status = ST_NOTFOUND;
                end
            end
            default: n_out = '0;
        endcase
    end

    ret_store u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (req),
        .i_rd_addr (r_cnt),
        .o_rd_data (rd_data),
        .o_rd_vld  (rd_vld)
    );

    ret_scan u_scan (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (in_xfer),
        .i_cmd     (r_item.cmd),
        .i_key_id  (r_item.problem_id),
        .i_act     (r_p_act),
        .i_idx     (r_p_idx),
        .i_ent_vld (rd_vld),
        .i_ent     (rd_data),
        .o_res     (res)
    );

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

endmodule

/* verif/tb_top.sv */
// testbench for ranked_entry_table_min_max_query: directed and random command streams
// with random idling on both channels, checked against a slot-table predictor class
// depends on ret_pkg and the ranked_entry_table_min_max_query rtl
`timescale 1ns / 1ps

module tb_top import ret_pkg::*; ;

    localparam int N_ITEMS = 1550;

    class rank_table_checker;
        logic        slot_used  [CAPACITY];
        logic [15:0] slot_id    [CAPACITY];
        logic [7:0]  slot_level [CAPACITY];
        t_out_item   pending_results[$];
        int          errors;

        function void clear_table();
            foreach (slot_used[i]) begin
                slot_used[i]  = 1'b0;
                slot_id[i]    = '0;
                slot_level[i] = '0;
            end
            pending_results.delete();
            errors = 0;
        endfunction

        function int find_id(logic [15:0] key);
            for (int i = 0; i < CAPACITY; i++) begin
                if (slot_used[i] && slot_id[i] == key) begin
                    return i;
                end
            end
            return -1;
        endfunction

        function int used_count();
            int n;
            n = 0;
            foreach (slot_used[i]) begin
                if (slot_used[i]) begin
                    n++;
                end
            end
            return n;
        endfunction

        function logic [15:0] pick_used_id();
            int k;
            k = $urandom_range(used_count() - 1);
            foreach (slot_used[i]) begin
                if (slot_used[i]) begin
                    if (k == 0) begin
                        return slot_id[i];
                    end
                    k--;
                end
            end
            return '0;
        endfunction

        function logic [15:0] absent_id();
            logic [15:0] id;
            do begin
                id = 16'($urandom);
            end while (find_id(id) >= 0);
            return id;
        endfunction

        // predict the result of one accepted command and update the table
        function void note_command(t_in_item it);
            t_out_item   res;
            int          slot;
            logic        seen;
            logic [23:0] best;
            logic [23:0] key;
            res = '0;
            res.status = ST_OK;
            case (it.cmd)
                CMD_ADD: begin
                    slot = find_id(it.problem_id);
                    if (slot < 0) begin
                        for (int i = 0; i < CAPACITY; i++) begin
                            if (!slot_used[i]) begin
                                slot = i;
                                break;
                            end
                        end
                    end
                    if (slot < 0) begin
                        res.status = ST_FULL;
                    end else begin
                        slot_used[slot]  = 1'b1;
                        slot_id[slot]    = it.problem_id;
                        slot_level[slot] = it.level;
                    end
                end
                CMD_HARD, CMD_EASY: begin
                    seen = 1'b0;
                    best = '0;
                    for (int i = 0; i < CAPACITY; i++) begin
                        if (slot_used[i]) begin
                            key = {slot_level[i], slot_id[i]};
                            if (!seen || (it.cmd == CMD_HARD ? key > best : key < best)) begin
                                best = key;
                                seen = 1'b1;
                            end
                        end
                    end
                    if (seen) begin
                        res.result_id = best[15:0];
                    end else begin
                        res.status = ST_EMPTY;
                    end
                end
                CMD_REM: begin
                    slot = find_id(it.problem_id);
                    if (slot < 0) begin
                        res.status = ST_NOTFOUND;
                    end else begin
                        slot_used[slot] = 1'b0;
                    end
                end
                default: ;
            endcase
            pending_results.insert(pending_results.size(), res);
        endfunction

        function void check_result(t_out_item got);
            t_out_item want;
            if (pending_results.size() == 0) begin
                $error("unexpected result: result_id %0h status %0d", got.result_id, got.status);
                errors++;
                return;
            end
            want = pending_results.pop_front();
            if (got.result_id !== want.result_id) begin
                $error("result_id mismatch: expected %0h, actual %0h",
                       want.result_id, got.result_id);
                errors++;
            end
            if (got.status !== want.status) begin
                $error("status mismatch: expected %0d, actual %0d", want.status, got.status);
                errors++;
            end
        endfunction
    endclass

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    t_in_item  in_data   = '0;
    logic      out_stall = 1'b0;
    logic      in_stall;
    logic      out_valid;
    t_out_item out_data;

    int                idle_pct = 8;
    int                items_sent = 0;
    rank_table_checker sb;

    ranked_entry_table_min_max_query dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    always #4 clk = ~clk;

    always @(posedge clk) begin
        out_stall <= ($urandom_range(99) < idle_pct);
    end

    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            sb.check_result(out_data);
        end
    end

    task automatic send_item(input logic [1:0] cmd, input logic [15:0] id,
                             input logic [7:0] lv);
        t_in_item it;
        it.cmd        = cmd;
        it.problem_id = id;
        it.level      = lv;
        while ($urandom_range(99) < idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        do begin
            @(posedge clk);
        end while (in_stall);
        sb.note_command(it);
        items_sent++;
    endtask

    task automatic send_random(input int pool, input logic [15:0] base);
        int          pick;
        logic [1:0]  cmd;
        logic [15:0] id;
        logic [7:0]  lv;
        cmd  = 2'($urandom_range(3));
        pick = $urandom_range(9);
        if (pick < 4 && sb.used_count() > 0) begin
            id = sb.pick_used_id();
        end else if (pick < 8) begin
            id = base + 16'($urandom_range(pool - 1));
        end else begin
            id = 16'($urandom);
        end
        // few levels half of the time so ties fall back to the identifier
        lv = $urandom_range(1) ? 8'($urandom_range(3)) : 8'($urandom);
        send_item(cmd, id, lv);
    endtask

    initial begin
        int          r;
        logic [15:0] base;
        sb = new;
        sb.clear_table();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed
        send_item(CMD_HARD, 16'h0000, 8'h00);
        send_item(CMD_EASY, 16'hFFFF, 8'hFF);
        send_item(CMD_REM,  16'h1234, 8'h00);
        send_item(CMD_ADD,  16'h0000, 8'h00);
        send_item(CMD_ADD,  16'hFFFF, 8'hFF);
        send_item(CMD_ADD,  16'h8000, 8'hFF);
        send_item(CMD_HARD, 16'h0000, 8'h00);
        send_item(CMD_EASY, 16'h0000, 8'h00);
        send_item(CMD_ADD,  16'hFFFF, 8'h00);
        send_item(CMD_HARD, 16'h0000, 8'h00);
        send_item(CMD_EASY, 16'h0000, 8'h00);
        send_item(CMD_REM,  16'h0000, 8'h00);
        send_item(CMD_EASY, 16'h0000, 8'h00);
        send_item(CMD_REM,  16'h0000, 8'h00);
        send_item(CMD_HARD, 16'hFFFF, 8'hFF);
        send_item(CMD_REM,  16'h8000, 8'hFF);
        send_item(CMD_REM,  16'hFFFF, 8'h00);
        send_item(CMD_EASY, 16'hFFFF, 8'hFF);
        send_item(CMD_ADD,  16'h5555, 8'hAA);
        send_item(CMD_ADD,  16'hAAAA, 8'h55);
        send_item(CMD_HARD, 16'h5555, 8'h55);
        send_item(CMD_EASY, 16'hAAAA, 8'hAA);
        send_item(CMD_REM,  16'h5555, 8'h00);
        send_item(CMD_REM,  16'hAAAA, 8'hFF);

        // small id pool, lots of hits, updates and removes
        base = 16'($urandom);
        repeat (300) send_random(16, base);

        // stretch with no idling on either side
        idle_pct = 0;
        repeat (150) send_random(16, base);
        idle_pct = 8;

        // fill the table
        while (sb.used_count() < CAPACITY) begin
            if ($urandom_range(99) < 85) begin
                send_item(CMD_ADD, sb.absent_id(), 8'($urandom));
            end else begin
                send_item($urandom_range(1) ? CMD_HARD : CMD_EASY, 16'($urandom),
                          8'($urandom));
            end
        end

        // traffic on a full table
        repeat (40) begin
            r = $urandom_range(9);
            if (r < 4) begin
                send_item(CMD_ADD, sb.absent_id(), 8'($urandom));
            end else if (r < 6) begin
                send_item(CMD_ADD, sb.pick_used_id(), 8'($urandom));
            end else if (r < 8) begin
                send_item(r[0] ? CMD_HARD : CMD_EASY, 16'($urandom), 8'($urandom));
            end else if (r == 8) begin
                send_item(CMD_REM, sb.pick_used_id(), 8'($urandom));
            end else begin
                send_item(CMD_REM, sb.absent_id(), 8'($urandom));
            end
        end

        // drain back to empty
        while (sb.used_count() > 0) begin
            r = $urandom_range(9);
            if (r < 8) begin
                send_item(CMD_REM, sb.pick_used_id(), 8'($urandom));
            end else if (r == 8) begin
                send_item(CMD_REM, sb.absent_id(), 8'($urandom));
            end else begin
                send_item($urandom_range(1) ? CMD_HARD : CMD_EASY, 16'($urandom),
                          8'($urandom));
            end
        end
        send_item(CMD_HARD, 16'($urandom), 8'($urandom));
        send_item(CMD_EASY, 16'($urandom), 8'($urandom));

        // wider pool
        base = 16'($urandom);
        while (items_sent < N_ITEMS) begin
            send_random(64, base);
        end
        in_valid <= 1'b0;

        while (sb.pending_results.size() != 0) begin
            @(posedge clk);
        end
        repeat (CAPACITY + 16) @(posedge clk);
        if (sb.errors == 0 && sb.pending_results.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule
